>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the queue core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SFQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SFQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SFQ_ASSERT(label, clk, rst_n, prop, msg)
`define SFQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> design/sfq_pkg.sv
// ---------------------------------------------------------------------------
// Searchable FIFO queue package
// Sizes, codes and controller/datapath signal bundles.
// ---------------------------------------------------------------------------
package sfq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int N_W   = $clog2(MAX_RESULTS + 1);
  localparam int CNT_W = (OCC_W > N_W) ? OCC_W : N_W;
  localparam int POS_W = 4;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [OCC_W-1:0] occ_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam idx_t       IDX_LAST  = idx_t'(QUEUE_DEPTH - 1);
  localparam occ_t       OCC_FULL  = occ_t'(QUEUE_DEPTH);
  localparam occ_t       OCC_ONE   = occ_t'(1);
  localparam cnt_t       CNT_ONE   = cnt_t'(1);
  localparam cnt_t       CNT_MAX   = cnt_t'(MAX_RESULTS);
  localparam logic [7:0] COUNT_MAX = 8'(MAX_RESULTS);

  localparam logic [2:0] MODE_ENQ  = 3'd0;
  localparam logic [2:0] MODE_DEQ  = 3'd1;
  localparam logic [2:0] MODE_LIST = 3'd2;
  localparam logic [2:0] MODE_SRCH = 3'd3;
  localparam logic [2:0] MODE_UPD  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic       load;
    logic       enq;
    logic       rd;
    logic       walk_adv;
    logic       deq_adv;
    logic       upd_wr;
    logic       emit;
    logic       emit_word;
    logic       emit_found;
    logic [1:0] emit_status;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       full;
    logic       empty;
    logic       n_zero;
    logic       match;
    logic       walk_last;
    logic       out_last;
  } sts_t;

endpackage

>>> design/sfq_in_if.sv
// ---------------------------------------------------------------------------
// Queue request channel
// Valid/ready channel carrying one request beat.
// ---------------------------------------------------------------------------
interface sfq_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [31:0] value;
  logic signed [31:0] new_value;
  logic [7:0]         count;

  modport source (output valid, output mode, output value, output new_value,
                  output count, input ready);
  modport sink (input valid, input mode, input value, input new_value,
                input count, output ready);
endinterface

>>> design/sfq_out_if.sv
// ---------------------------------------------------------------------------
// Queue result channel
// Valid/ready channel carrying one result beat.
// ---------------------------------------------------------------------------
interface sfq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] word;
  logic               found;
  logic [3:0]         position;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, output word, output found, output position,
                  output status, output last, input ready);
  modport sink (input valid, input word, input found, input position,
                input status, input last, output ready);
endinterface

>>> design/sfq_datapath.sv
// ---------------------------------------------------------------------------
// Queue datapath
// Entry memory, ring pointers, walk counters and the result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfq_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  sfq_pkg::cmd_t      cmd,
  output sfq_pkg::sts_t      sts,
  input  logic [2:0]         in_mode,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_new_value,
  input  logic [7:0]         in_count,
  output logic signed [31:0] out_word,
  output logic               out_found,
  output logic [3:0]         out_position,
  output logic [1:0]         out_status,
  output logic               out_last
);

  logic [31:0] mem [sfq_pkg::QUEUE_DEPTH];

  sfq_pkg::idx_t head_r;
  sfq_pkg::idx_t tail_r;
  sfq_pkg::occ_t occ_r;
  sfq_pkg::idx_t walk_r;
  sfq_pkg::cnt_t pos_r;
  sfq_pkg::cnt_t n_r;
  logic [2:0]    mode_r;
  logic [31:0]   value_r;
  logic [31:0]   new_value_r;
  logic [31:0]   rd_data_r;

  logic signed [31:0] out_word_r;
  logic               out_found_r;
  logic [3:0]         out_position_r;
  logic [1:0]         out_status_r;
  logic               out_last_r;

  logic [7:0]    lim_src;
  sfq_pkg::cnt_t lim_cnt;
  sfq_pkg::cnt_t occ_cnt;
  sfq_pkg::cnt_t n_calc;
  sfq_pkg::cnt_t pos_inc;
  logic          wr_en;
  sfq_pkg::idx_t wr_addr;
  logic [31:0]   wr_data;

  function automatic sfq_pkg::idx_t ring_next(input sfq_pkg::idx_t i);
    ring_next = (i == sfq_pkg::IDX_LAST) ? '0 : i + sfq_pkg::idx_t'(1);
  endfunction

  always_comb begin
    lim_src = (in_mode == sfq_pkg::MODE_LIST) ? 8'hFF : in_count;
    lim_cnt = (lim_src > sfq_pkg::COUNT_MAX) ? sfq_pkg::CNT_MAX : sfq_pkg::cnt_t'(lim_src);
    occ_cnt = sfq_pkg::cnt_t'(occ_r);
    n_calc  = (occ_cnt < lim_cnt) ? occ_cnt : lim_cnt;
    pos_inc = pos_r + sfq_pkg::CNT_ONE;
    wr_en   = cmd.enq | cmd.upd_wr;
    wr_addr = cmd.enq ? tail_r : walk_r;
    wr_data = cmd.enq ? value_r : new_value_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[walk_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      occ_r  <= '0;
    end else begin
      if (cmd.enq) begin
        tail_r <= ring_next(tail_r);
        occ_r  <= occ_r + sfq_pkg::OCC_ONE;
      end else if (cmd.deq_adv) begin
        head_r <= ring_next(head_r);
        occ_r  <= occ_r - sfq_pkg::OCC_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r      <= in_mode;
      value_r     <= in_value;
      new_value_r <= in_new_value;
      n_r         <= n_calc;
      walk_r      <= head_r;
      pos_r       <= '0;
    end else if (cmd.walk_adv) begin
      walk_r <= ring_next(walk_r);
      pos_r  <= pos_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.emit_word) begin
        out_word_r     <= rd_data_r;
        out_found_r    <= 1'b0;
        out_position_r <= '0;
        out_status_r   <= sfq_pkg::ST_OK;
        out_last_r     <= (pos_inc == n_r);
      end else begin
        out_word_r     <= '0;
        out_found_r    <= cmd.emit_found;
        out_position_r <= cmd.emit_found ? pos_r[sfq_pkg::POS_W-1:0] : '0;
        out_status_r   <= cmd.emit_status;
        out_last_r     <= 1'b1;
      end
    end
  end

  always_comb begin
    sts.mode      = mode_r;
    sts.full      = (occ_r == sfq_pkg::OCC_FULL);
    sts.empty     = (occ_r == '0);
    sts.n_zero    = (n_r == '0);
    sts.match     = (rd_data_r == value_r);
    sts.walk_last = (pos_inc == occ_cnt);
    sts.out_last  = out_last_r;
  end

  assign out_word     = out_word_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;
  assign out_status   = out_status_r;
  assign out_last     = out_last_r;

  `SFQ_ASSERT(a_occ_bound, clk, rst_n, occ_r <= sfq_pkg::OCC_FULL, "occupancy above depth")
  `SFQ_ASSERT_IMPL(a_empty_ptrs, clk, rst_n, occ_r == '0, head_r == tail_r, "empty ring with split pointers")
  `SFQ_ASSERT_IMPL(a_no_enq_full, clk, rst_n, cmd.enq, occ_r != sfq_pkg::OCC_FULL, "write into a full ring")

endmodule

>>> design/sfq_ctrl.sv
// ---------------------------------------------------------------------------
// Queue controller
// Sequences one request: decode, entry walk and result beats.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sfq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  sfq_pkg::sts_t sts,
  output sfq_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_READ,
    S_EVAL,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   in_fire;
  logic   walk_mode;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign out_valid = out_valid_r;
  assign walk_mode = (sts.mode == sfq_pkg::MODE_DEQ) || (sts.mode == sfq_pkg::MODE_LIST);

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (sts.mode == sfq_pkg::MODE_ENQ) begin
          cmd.emit        = 1'b1;
          cmd.enq         = !sts.full;
          cmd.emit_status = sts.full ? sfq_pkg::ST_FULL : sfq_pkg::ST_OK;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_OUT;
        end else if (sts.mode > sfq_pkg::MODE_UPD || sts.empty ||
                     (sts.mode == sfq_pkg::MODE_DEQ && sts.n_zero)) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = sfq_pkg::ST_EMPTY;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_OUT;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        priority if (walk_mode) begin
          cmd.emit      = 1'b1;
          cmd.emit_word = 1'b1;
          cmd.walk_adv  = 1'b1;
          cmd.deq_adv   = (sts.mode == sfq_pkg::MODE_DEQ);
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else if (sts.match) begin
          cmd.emit        = 1'b1;
          cmd.emit_found  = 1'b1;
          cmd.emit_status = sfq_pkg::ST_OK;
          cmd.upd_wr      = (sts.mode == sfq_pkg::MODE_UPD);
          out_valid_nxt   = 1'b1;
          state_nxt       = S_OUT;
        end else if (sts.walk_last) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = (sts.mode == sfq_pkg::MODE_UPD) ? sfq_pkg::ST_EMPTY
                                                            : sfq_pkg::ST_OK;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_OUT;
        end else begin
          cmd.walk_adv = 1'b1;
          state_nxt    = S_READ;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = sts.out_last ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SFQ_ASSERT(a_one_side, clk, rst_n, !(in_ready && out_valid_r), "request taken while a result is pending")
  `SFQ_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_fire, !in_ready, "second request taken during decode")
  `SFQ_ASSERT_IMPL(a_valid_in_out, clk, rst_n, out_valid_r, state_r == S_OUT, "result shown outside the output state")

endmodule

>>> design/searchable_fifo_queue_core.sv
// ---------------------------------------------------------------------------
// Searchable FIFO queue core
// Bounded ring queue of signed words with dequeue, list, search and update.
// ---------------------------------------------------------------------------
// One request is handled at a time; in_chan.ready is high only while the core
// is idle. Enqueue and every status result that needs no walk of the entries
// come from the decode state. Each stored entry that a dequeue, list, search or
// update walks takes a registered read of the entry memory and then a step to
// evaluate it, and every result beat waits in the output register until taken.
// A search or update stops at its first match; a dequeue or list goes on to the
// next entry once each word beat is taken. Stored entries come back in arrival
// order, at most 16 result beats per request, with last set on the final one.
module searchable_fifo_queue_core (
  input logic      clk,
  input logic      rst_n,
  sfq_in_if.sink   in_chan,
  sfq_out_if.source out_chan
);

  sfq_pkg::cmd_t cmd;
  sfq_pkg::sts_t sts;

  sfq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfq_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_mode      (in_chan.mode),
    .in_value     (in_chan.value),
    .in_new_value (in_chan.new_value),
    .in_count     (in_chan.count),
    .out_word     (out_chan.word),
    .out_found    (out_chan.found),
    .out_position (out_chan.position),
    .out_status   (out_chan.status),
    .out_last     (out_chan.last)
  );

endmodule

>>> tb/searchable_fifo_queue_core_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Searchable FIFO queue core testbench
// Drives enqueue, dequeue, list, search, update and reserved-mode requests
// through the request channel, tracks the ring queue in a local predictor
// and checks every result beat in order, with random gaps on both channels.
// ---------------------------------------------------------------------------
module searchable_fifo_queue_core_test;

  localparam logic [2:0] MODE_RSVD_FIRST = 3'd5;
  localparam logic [2:0] MODE_RSVD_LAST  = 3'd7;

  typedef struct {
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic signed [31:0] new_value;
    logic [7:0]         count;
    logic               hold;
  } request_t;

  typedef struct {
    logic signed [31:0] word;
    logic               found;
    logic [3:0]         position;
    logic [1:0]         status;
    logic               last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  sfq_in_if  in_chan ();
  sfq_out_if out_chan ();

  searchable_fifo_queue_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_t pending_requests[$];
  result_t  due_results[$];
  request_t cur_req;

  logic signed [31:0] ring_words [sfq_pkg::QUEUE_DEPTH];
  int ring_head;
  int ring_tail;
  int ring_fill;

  logic signed [31:0] word_pool [8] = '{32'sd0, -32'sd1, 32'sd1, 32'sh7fff_ffff,
                                        32'sh8000_0000, 32'sd42, -32'sd42,
                                        32'sh5555_5555};

  int n_total;
  int n_accepted;
  int n_beats;
  int n_errors;
  int n_refused;
  int n_matched;
  int peak_fill;
  int send_gap;
  int recv_gap;
  bit send_calm;
  bit recv_calm;

  function automatic logic signed [31:0] pick_word();
    if ($urandom_range(0, 1) == 0)
      return word_pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  function automatic void add_request(logic [2:0] mode, logic signed [31:0] value,
                                      logic signed [31:0] new_value,
                                      logic [7:0] count, logic hold);
    request_t r;
    r.mode      = mode;
    r.value     = value;
    r.new_value = new_value;
    r.count     = count;
    r.hold      = hold;
    pending_requests.push_back(r);
    n_total++;
  endfunction

  function automatic void post_result(logic signed [31:0] word, logic found,
                                      logic [3:0] position, logic [1:0] status,
                                      logic last);
    result_t r;
    r.word     = word;
    r.found    = found;
    r.position = position;
    r.status   = status;
    r.last     = last;
    due_results.push_back(r);
  endfunction

  function automatic void apply_request(request_t r);
    int n;
    int pos;
    int idx;
    if (r.mode == sfq_pkg::MODE_ENQ) begin
      if (ring_fill >= sfq_pkg::QUEUE_DEPTH) begin
        post_result(0, 1'b0, 4'd0, sfq_pkg::ST_FULL, 1'b1);
        n_refused++;
      end else begin
        ring_words[ring_tail] = r.value;
        ring_tail = (ring_tail + 1) % sfq_pkg::QUEUE_DEPTH;
        ring_fill++;
        if (ring_fill > peak_fill)
          peak_fill = ring_fill;
        post_result(0, 1'b0, 4'd0, sfq_pkg::ST_OK, 1'b1);
      end
    end else if (r.mode > sfq_pkg::MODE_UPD || ring_fill == 0) begin
      post_result(0, 1'b0, 4'd0, sfq_pkg::ST_EMPTY, 1'b1);
    end else if (r.mode == sfq_pkg::MODE_DEQ || r.mode == sfq_pkg::MODE_LIST) begin
      n = (r.mode == sfq_pkg::MODE_DEQ) ? int'(r.count) : ring_fill;
      if (n > ring_fill)
        n = ring_fill;
      if (n > sfq_pkg::MAX_RESULTS)
        n = sfq_pkg::MAX_RESULTS;
      if (n == 0) begin
        post_result(0, 1'b0, 4'd0, sfq_pkg::ST_EMPTY, 1'b1);
      end else begin
        idx = ring_head;
        for (int k = 0; k < n; k++) begin
          post_result(ring_words[idx], 1'b0, 4'd0, sfq_pkg::ST_OK, k == n - 1);
          idx = (idx + 1) % sfq_pkg::QUEUE_DEPTH;
        end
        if (r.mode == sfq_pkg::MODE_DEQ) begin
          ring_head = idx;
          ring_fill -= n;
        end
      end
    end else begin
      pos = ring_fill;
      for (int k = ring_fill - 1; k >= 0; k--)
        if (ring_words[(ring_head + k) % sfq_pkg::QUEUE_DEPTH] == r.value)
          pos = k;
      if (pos < ring_fill) begin
        if (r.mode == sfq_pkg::MODE_UPD)
          ring_words[(ring_head + pos) % sfq_pkg::QUEUE_DEPTH] = r.new_value;
        post_result(0, 1'b1, 4'(pos), sfq_pkg::ST_OK, 1'b1);
        n_matched++;
      end else begin
        post_result(0, 1'b0, 4'd0,
                    (r.mode == sfq_pkg::MODE_SRCH) ? sfq_pkg::ST_OK : sfq_pkg::ST_EMPTY,
                    1'b1);
      end
    end
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endfunction

  // Request driver: holds each beat until taken, then waits a drawn gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        apply_request(cur_req);
        n_accepted++;
        if ($urandom_range(0, 19) == 0)
          send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 3);
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_chan.valid <= 1'b0;
        end else if (pending_requests.size() > 0 &&
                     !(pending_requests[0].hold && due_results.size() != 0)) begin
          cur_req = pending_requests.pop_front();
          in_chan.valid     <= 1'b1;
          in_chan.mode      <= cur_req.mode;
          in_chan.value     <= cur_req.value;
          in_chan.new_value <= cur_req.new_value;
          in_chan.count     <= cur_req.count;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each taken beat with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        n_beats++;
        if (due_results.size() == 0) begin
          $error("unexpected result: word %0d status %0d", out_chan.word,
                 out_chan.status);
          n_errors++;
        end else begin
          want = due_results.pop_front();
          check_field("word", want.word, out_chan.word);
          check_field("found", want.found, out_chan.found);
          check_field("position", want.position, out_chan.position);
          check_field("status", want.status, out_chan.status);
          check_field("last", want.last, out_chan.last);
        end
        if ($urandom_range(0, 19) == 0)
          recv_calm = !recv_calm;
        recv_gap = recv_calm ? 0 : $urandom_range(0, 3);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  initial begin
    int sel;
    int grow_pct;
    bit filling;
    logic [2:0] mode;
    logic signed [31:0] value;
    logic signed [31:0] new_value;
    logic [7:0] count;

    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.mode      = sfq_pkg::MODE_ENQ;
    in_chan.value     = '0;
    in_chan.new_value = '0;
    in_chan.count     = '0;
    out_chan.ready    = 1'b0;
    ring_head         = 0;
    ring_tail         = 0;
    ring_fill         = 0;
    filling           = 1'b0;

    add_request(sfq_pkg::MODE_DEQ, 0, 0, 8'd255, 1'b0);
    add_request(sfq_pkg::MODE_LIST, 0, 0, 0, 1'b0);
    add_request(sfq_pkg::MODE_SRCH, 32'sd42, 0, 0, 1'b0);
    add_request(sfq_pkg::MODE_UPD, 32'sd42, 32'sd7, 0, 1'b0);
    for (int i = 0; i < sfq_pkg::QUEUE_DEPTH; i++) begin
      if (i < 8)
        value = word_pool[i];
      else if (i == 10)
        value = word_pool[5];
      else if (i == sfq_pkg::QUEUE_DEPTH - 1)
        value = 32'sh0bad_f00d;
      else
        value = $urandom();
      add_request(sfq_pkg::MODE_ENQ, value, $urandom(), 8'($urandom()), 1'b0);
    end
    add_request(sfq_pkg::MODE_ENQ, -32'sd7, 0, 0, 1'b0);
    add_request(sfq_pkg::MODE_LIST, 0, 0, 0, 1'b0);
    add_request(sfq_pkg::MODE_UPD, 32'sh0bad_f00d, 32'sh8000_0000, 0, 1'b0);
    add_request(sfq_pkg::MODE_UPD, 32'sd42, -32'sd1, 0, 1'b0);
    add_request(sfq_pkg::MODE_SRCH, 32'sh1357_9bdf, 0, 0, 1'b0);
    add_request(sfq_pkg::MODE_UPD, 32'sh1357_9bdf, 0, 0, 1'b0);
    add_request(sfq_pkg::MODE_DEQ, 0, 0, 8'd0, 1'b0);
    add_request(MODE_RSVD_LAST, 0, 0, 0, 1'b0);
    add_request(sfq_pkg::MODE_DEQ, 0, 0, 8'd255, 1'b0);

    // Alternate growing and draining stretches so the ring wraps and fills.
    for (int i = 0; i < 282; i++) begin
      if (i % 48 == 0)
        filling = !filling;
      grow_pct  = filling ? 55 : 25;
      value     = pick_word();
      new_value = pick_word();
      count     = 8'($urandom());
      if ($urandom_range(0, 99) < grow_pct) begin
        mode = sfq_pkg::MODE_ENQ;
      end else begin
        sel = $urandom_range(0, 19);
        if (sel < 6) begin
          mode = sfq_pkg::MODE_DEQ;
          if ($urandom_range(0, 3) != 0)
            count = 8'($urandom_range(0, 5));
        end else if (sel < 9) begin
          mode = sfq_pkg::MODE_LIST;
        end else if (sel < 14) begin
          mode = sfq_pkg::MODE_SRCH;
        end else if (sel < 19) begin
          mode = sfq_pkg::MODE_UPD;
        end else begin
          mode = 3'($urandom_range(MODE_RSVD_FIRST, MODE_RSVD_LAST));
        end
      end
      add_request(mode, value, new_value, count, i == 0 || i == 140);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted != n_total || due_results.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d requests and checked %0d result beats; peak fill %0d,",
             n_accepted, n_beats, peak_fill);
    $display("%0d enqueues refused as full, %0d searches or updates matched.",
             n_refused, n_matched);
    if (n_errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/sfq_pkg.sv
design/sfq_in_if.sv
design/sfq_out_if.sv
design/sfq_datapath.sv
design/sfq_ctrl.sv
design/searchable_fifo_queue_core.sv
tb/searchable_fifo_queue_core_test.sv
